// ===== rtl/uvsg_pkg.sv =====
// uvsg_pkg: shared types and constants of the uv sphere mesh generator
// element kinds, register indexes and reset values, sine polynomial coefficients
// no dependencies
`default_nettype none

package uvsg_pkg;

  // default grid limits for the top level parameters
  localparam int DEF_MAX_SECTORS = 256;
  localparam int DEF_MAX_STACKS  = 256;

  // kind of one mesh element
  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } elem_kind_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SECTOR_COUNT = 2'd0;
  localparam logic [1:0] CFG_STACK_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SECTOR_STEP  = 2'd2;
  localparam logic [1:0] CFG_STACK_STEP   = 2'd3;

  // configuration reset values
  localparam logic [8:0]  RST_SECTOR_COUNT = 9'd16;
  localparam logic [8:0]  RST_STACK_COUNT  = 9'd16;
  localparam logic [15:0] RST_SECTOR_STEP  = 16'd4096;
  localparam logic [15:0] RST_STACK_STEP   = 16'd2048;

  // angles in 1/65536 turn
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // odd sine coefficients over the first quadrant, unsigned q30
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  // register stages of one sine unit, angle in to value out
  localparam int SIN_LAT = 7;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== rtl/uvsg_queue.sv =====
// uvsg_queue: short fifo that carries classified elements from front to back
// uses uvsg_pkg for the depth
`default_nettype none

module uvsg_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              full,
  output logic              empty,
  output logic [W-1:0]      head
);
  import uvsg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     ents [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = ents[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ents[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uvsg_sin.sv =====
// uvsg_sin: pipelined sine of a 16-bit turn angle, q1.15 result
// odd polynomial in horner form, at most one multiply per stage; uses uvsg_pkg
`default_nettype none

module uvsg_sin (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        angle,
  output logic signed [15:0]      value
);
  import uvsg_pkg::*;

  logic [14:0] fold;
  logic [30:0] t0, t1, t2, t3, t4, t5;
  logic        n0, n1, n2, n3, n4, n5;
  logic [31:0] q1, q2, q3, q4;
  logic [31:0] p2, p3, p4, p5;
  logic [63:0] sq, m2, m3, m4, m5, fin;
  logic [34:0] rnd;
  logic [19:0] mag;
  logic [14:0] sat;

  // fold into the first quadrant, odd quadrants mirror
  always_comb begin
    if (angle[14]) begin
      fold = 15'(QUARTER_TURN) - {1'b0, angle[13:0]};
    end else begin
      fold = {1'b0, angle[13:0]};
    end
  end

  // one multiply between each pair of stages
  assign sq  = 64'(t0) * 64'(t0);
  assign m2  = 64'(q1) * 64'(SIN_C9);
  assign m3  = 64'(q2) * 64'(p2);
  assign m4  = 64'(q3) * 64'(p3);
  assign m5  = 64'(q4) * 64'(p4);
  assign fin = 64'(t5) * 64'(p5);

  // round to q15 and saturate
  assign rnd = {1'b0, fin[63:30]} + 35'd16384;
  assign mag = rnd[34:15];
  assign sat = (mag > 20'd32767) ? 15'h7fff : mag[14:0];

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= {fold, 16'b0};
      n0 <= angle[15];
      t1 <= t0;
      n1 <= n0;
      q1 <= sq[61:30];
      t2 <= t1;
      n2 <= n1;
      q2 <= q1;
      p2 <= SIN_C7 - m2[61:30];
      t3 <= t2;
      n3 <= n2;
      q3 <= q2;
      p3 <= SIN_C5 - m3[61:30];
      t4 <= t3;
      n4 <= n3;
      q4 <= q3;
      p4 <= SIN_C3 - m4[61:30];
      t5 <= t4;
      n5 <= n4;
      p5 <= SIN_C1 - m5[61:30];
      value <= n5 ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uvsg_front.sv =====
// uvsg_front: accepts advance items, steps the mesh counters, queues elements
// skips the triangles left out at the poles; uses uvsg_pkg
`default_nettype none

module uvsg_front #(
  parameter int MAX_SECTORS = uvsg_pkg::DEF_MAX_SECTORS,
  parameter int MAX_STACKS  = uvsg_pkg::DEF_MAX_STACKS,
  parameter int W           = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               restart,
  input  wire logic [$clog2(MAX_SECTORS+1)-1:0]   sectors,
  input  wire logic [$clog2(MAX_STACKS+1)-1:0]    stacks,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output logic [W-1:0]                            q_data
);
  import uvsg_pkg::*;

  localparam int CW = $clog2(MAX_SECTORS + 1);
  localparam int RW = $clog2(MAX_STACKS + 1);

  typedef enum logic [2:0] {
    PH_VERT = 3'b001,
    PH_TRI  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t        ph;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic          half;
  } ctr_t;

  ctr_t       ctr;
  ctr_t       cur;
  ctr_t       ctr_next;
  logic       accept;
  elem_kind_t kind;

  // drop triangles that are left out at the poles
  function automatic ctr_t settle(input ctr_t x, input logic [CW-1:0] s,
                                  input logic [RW-1:0] t);
    logic [CW:0] c2;
    settle = x;
    c2 = {1'b0, x.col} + 1'b1;
    if (x.ph == PH_TRI) begin
      if (x.row >= t) begin
        settle.ph = PH_DONE;
      end else if (t == RW'(1)) begin
        settle.ph = PH_DONE;
      end else if (!x.half && x.row == '0) begin
        settle.half = 1'b1;
      end else if (x.half && ({1'b0, x.row} + 1'b1) >= {1'b0, t}) begin
        settle.half = 1'b0;
        if (c2 >= {1'b0, s}) begin
          settle.ph = PH_DONE;
        end else begin
          settle.col = c2[CW-1:0];
        end
      end
    end
  endfunction

  // step to the next triangle of the quad grid
  function automatic ctr_t tri_step(input ctr_t x, input logic [CW-1:0] s,
                                    input logic [RW-1:0] t);
    logic [CW:0] c2;
    logic [RW:0] r2;
    tri_step = x;
    c2 = {1'b0, x.col} + 1'b1;
    r2 = {1'b0, x.row} + 1'b1;
    if (!x.half) begin
      tri_step.half = 1'b1;
    end else begin
      tri_step.half = 1'b0;
      if (c2 >= {1'b0, s}) begin
        tri_step.col = '0;
        tri_step.row = r2[RW-1:0];
        if (r2 >= {1'b0, t}) begin
          tri_step.ph = PH_DONE;
        end
      end else begin
        tri_step.col = c2[CW-1:0];
      end
    end
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // state the item works on, restart clears it first
  always_comb begin
    if (restart) begin
      cur.ph   = PH_VERT;
      cur.row  = '0;
      cur.col  = '0;
      cur.half = 1'b0;
    end else begin
      cur = ctr;
    end
  end

  // counter update for one accepted item
  always_comb begin
    ctr_next = cur;
    case (cur.ph)
      PH_VERT: begin
        if (cur.col >= sectors) begin
          ctr_next.col = '0;
          if (cur.row >= stacks) begin
            ctr_next.ph   = PH_TRI;
            ctr_next.row  = '0;
            ctr_next.half = 1'b0;
            ctr_next      = settle(ctr_next, sectors, stacks);
          end else begin
            ctr_next.row = cur.row + 1'b1;
          end
        end else begin
          ctr_next.col = cur.col + 1'b1;
        end
      end
      PH_TRI: begin
        ctr_next = settle(tri_step(cur, sectors, stacks), sectors, stacks);
      end
      default: begin
        ctr_next.ph = PH_DONE;
      end
    endcase
  end

  // element for the back: row, column, half, last, kind
  assign kind   = (cur.ph == PH_TRI) ? KIND_TRIANGLE : KIND_VERTEX;
  assign q_push = accept && (cur.ph == PH_VERT || cur.ph == PH_TRI);
  assign q_data = {cur.row, cur.col, cur.half, (ctr_next.ph == PH_DONE), kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr.ph   <= PH_VERT;
      ctr.row  <= '0;
      ctr.col  <= '0;
      ctr.half <= 1'b0;
    end else if (accept) begin
      ctr <= ctr_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uvsg_back.sv =====
// uvsg_back: turns queued elements into vertex coordinates or index triples
// angle and index stage, four sine units, q15 products, output register
// uses uvsg_pkg and uvsg_sin
`default_nettype none

module uvsg_back #(
  parameter int MAX_SECTORS = uvsg_pkg::DEF_MAX_SECTORS,
  parameter int MAX_STACKS  = uvsg_pkg::DEF_MAX_STACKS,
  parameter int W           = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [$clog2(MAX_SECTORS+1)-1:0]   sectors,
  input  wire logic [15:0]                        sect_angle_inc,
  input  wire logic [15:0]                        stack_angle_inc,
  input  wire logic                               q_empty,
  input  wire logic [W-1:0]                       q_head,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_kind,
  output logic [15:0]                             out_x,
  output logic [15:0]                             out_y,
  output logic [15:0]                             out_z,
  output logic [16:0]                             out_first,
  output logic [16:0]                             out_second,
  output logic [16:0]                             out_third,
  output logic                                    out_last
);
  import uvsg_pkg::*;

  localparam int CW = $clog2(MAX_SECTORS + 1);
  localparam int RW = $clog2(MAX_STACKS + 1);

  logic          en;
  elem_kind_t    h_kind;
  logic          h_last;
  logic          h_half;
  logic [CW-1:0] h_col;
  logic [RW-1:0] h_row;
  logic [31:0]   u_prod;
  logic [31:0]   v_prod;
  logic [31:0]   a_prod;

  logic          vld1;
  elem_kind_t    kind1;
  logic          last1;
  logic          half1;
  logic [15:0]   u1;
  logic [15:0]   v1;
  logic [16:0]   a1;

  logic          dl_vld  [SIN_LAT];
  elem_kind_t    dl_kind [SIN_LAT];
  logic          dl_last [SIN_LAT];
  logic          dl_half [SIN_LAT];
  logic [16:0]   dl_a    [SIN_LAT];

  logic signed [15:0] cos_v, sin_v, cos_u, sin_u;
  logic [16:0]   ia, ib, ia1, ib1;

  // q15 product with the magnitude rounded half up
  function automatic logic [15:0] mul_q15(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic [15:0] ma;
    logic [15:0] mb;
    logic [31:0] pr;
    logic [15:0] r;
    ma = a[15] ? 16'(-a) : 16'(a);
    mb = b[15] ? 16'(-b) : 16'(b);
    pr = 32'(ma) * 32'(mb) + 32'd16384;
    r  = pr[30:15];
    return (a[15] ^ b[15]) ? -r : r;
  endfunction

  // whole pipeline moves when the output register can take an item
  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  // queue head fields
  assign h_kind = elem_kind_t'(q_head[0]);
  assign h_last = q_head[1];
  assign h_half = q_head[2];
  assign h_col  = q_head[3 +: CW];
  assign h_row  = q_head[3 + CW +: RW];

  // grid angles and first vertex index of the quad
  assign u_prod = 32'(h_col) * 32'(sect_angle_inc);
  assign v_prod = 32'(h_row) * 32'(stack_angle_inc);
  assign a_prod = 32'(h_row) * 32'({1'b0, sectors} + 1'b1) + 32'(h_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1 <= h_kind;
      last1 <= h_last;
      half1 <= h_half;
      u1    <= u_prod[15:0];
      v1    <= QUARTER_TURN - v_prod[15:0];
      a1    <= a_prod[16:0];
    end
  end

  // sine units, cosine as sine a quarter turn on
  uvsg_sin u_sin_cv (.clk(clk), .en(en), .angle(v1 + QUARTER_TURN), .value(cos_v));
  uvsg_sin u_sin_sv (.clk(clk), .en(en), .angle(v1),                .value(sin_v));
  uvsg_sin u_sin_cu (.clk(clk), .en(en), .angle(u1 + QUARTER_TURN), .value(cos_u));
  uvsg_sin u_sin_su (.clk(clk), .en(en), .angle(u1),                .value(sin_u));

  // element info travels beside the sine units
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIN_LAT; i++) begin
        dl_vld[i] <= 1'b0;
      end
    end else if (en) begin
      dl_vld[0] <= vld1;
      for (int i = 1; i < SIN_LAT; i++) begin
        dl_vld[i] <= dl_vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_kind[0] <= kind1;
      dl_last[0] <= last1;
      dl_half[0] <= half1;
      dl_a[0]    <= a1;
      for (int i = 1; i < SIN_LAT; i++) begin
        dl_kind[i] <= dl_kind[i-1];
        dl_last[i] <= dl_last[i-1];
        dl_half[i] <= dl_half[i-1];
        dl_a[i]    <= dl_a[i-1];
      end
    end
  end

  // triangle corners of the quad
  assign ia  = dl_a[SIN_LAT-1];
  assign ib  = ia + 17'(sectors) + 17'd1;
  assign ia1 = ia + 17'd1;
  assign ib1 = ib + 17'd1;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dl_vld[SIN_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind <= dl_kind[SIN_LAT-1];
      out_last <= dl_last[SIN_LAT-1];
      if (dl_kind[SIN_LAT-1] == KIND_TRIANGLE) begin
        out_x      <= '0;
        out_y      <= '0;
        out_z      <= '0;
        out_second <= ib;
        if (dl_half[SIN_LAT-1]) begin
          out_first <= ia1;
          out_third <= ib1;
        end else begin
          out_first <= ia;
          out_third <= ia1;
        end
      end else begin
        out_x      <= mul_q15(cos_v, cos_u);
        out_y      <= mul_q15(cos_v, sin_u);
        out_z      <= sin_v;
        out_first  <= '0;
        out_second <= '0;
        out_third  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uv_sphere_mesh_generator.sv =====
// Takes one advance item per clock while the queue has room and returns at most one mesh
// element per item: all grid vertices of the sphere row by row, then the triangle index
// triples, with tlast on the final element; an advance after the mesh is complete returns
// nothing until a restart. Elements leave at one per clock while m_tready stays high. An
// element passes from the queue into the angle stage, through the seven-stage sine
// polynomial, then into the output register that also forms the products; the sine units
// set the depth of that path, and a four-entry queue lets the input side run on while the
// output side is stalled.
// Depends on uvsg_pkg, uvsg_front, uvsg_queue, uvsg_back and uvsg_sin.
`default_nettype none

module uv_sphere_mesh_generator #(
  parameter int MAX_SECTORS = uvsg_pkg::DEF_MAX_SECTORS,
  parameter int MAX_STACKS  = uvsg_pkg::DEF_MAX_STACKS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // slave side
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,    // [0] restart
  // master side
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [103:0]       m_tdata,    // coord_x, coord_y, coord_z, index_first,
                                         // index_second, index_third
  output logic               m_tuser,    // elem_kind
  output logic               m_tlast,
  // configuration writes
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import uvsg_pkg::*;

  localparam int CW = $clog2(MAX_SECTORS + 1);
  localparam int RW = $clog2(MAX_STACKS + 1);
  localparam int QW = RW + CW + 3;

  logic [8:0]    sector_count;
  logic [8:0]    stack_count;
  logic [15:0]   sector_step_angle;
  logic [15:0]   stack_step_angle;
  logic [CW-1:0] sectors;
  logic [RW-1:0] stacks;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_data;
  logic [QW-1:0] q_head;

  logic          out_kind;
  logic          out_last;
  logic [15:0]   out_x, out_y, out_z;
  logic [16:0]   out_first, out_second, out_third;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count      <= RST_SECTOR_COUNT;
      stack_count       <= RST_STACK_COUNT;
      sector_step_angle <= RST_SECTOR_STEP;
      stack_step_angle  <= RST_STACK_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SECTOR_COUNT: sector_count      <= cfg_data[8:0];
        CFG_STACK_COUNT:  stack_count       <= cfg_data[8:0];
        CFG_SECTOR_STEP:  sector_step_angle <= cfg_data;
        CFG_STACK_STEP:   stack_step_angle  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // counts in use: zero reads as one, above the limit reads as the limit
  always_comb begin
    if (sector_count == '0) begin
      sectors = CW'(1);
    end else if (32'(sector_count) > 32'(MAX_SECTORS)) begin
      sectors = CW'(MAX_SECTORS);
    end else begin
      sectors = CW'(sector_count);
    end
    if (stack_count == '0) begin
      stacks = RW'(1);
    end else if (32'(stack_count) > 32'(MAX_STACKS)) begin
      stacks = RW'(MAX_STACKS);
    end else begin
      stacks = RW'(stack_count);
    end
  end

  uvsg_front #(
    .MAX_SECTORS(MAX_SECTORS),
    .MAX_STACKS (MAX_STACKS),
    .W          (QW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .restart (s_tdata[0]),
    .sectors (sectors),
    .stacks  (stacks),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  uvsg_queue #(
    .W(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  uvsg_back #(
    .MAX_SECTORS(MAX_SECTORS),
    .MAX_STACKS (MAX_STACKS),
    .W          (QW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .sectors        (sectors),
    .sect_angle_inc (sector_step_angle),
    .stack_angle_inc(stack_step_angle),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_kind       (out_kind),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_first      (out_first),
    .out_second     (out_second),
    .out_third      (out_third),
    .out_last       (out_last)
  );

  // result packing
  assign m_tdata = {5'b0, out_third, out_second, out_first, out_z, out_y, out_x};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for the uv sphere mesh generator, directed table then
// random meshes under several idling phases, every element checked against a local model
// or a typed-in element; depends on uvsg_pkg and the uv_sphere_mesh_generator rtl
module testbench;
  import uvsg_pkg::*;

  localparam int MAX_S           = DEF_MAX_SECTORS;
  localparam int MAX_T           = DEF_MAX_STACKS;
  localparam int WATCHDOG        = 4000;
  localparam int DRAIN           = 24;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 110;

  // one mesh element as seen on the master side
  typedef struct packed {
    elem_kind_t         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [16:0]        i1;
    logic [16:0]        i2;
    logic [16:0]        i3;
    logic               last;
  } mesh_elem_t;

  // per item: use a typed-in element instead of the model
  typedef struct packed {
    bit         lit;
    bit         lit_out;
    mesh_elem_t elem;
  } item_note_t;

  // one row of the directed table
  typedef struct packed {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [15:0] data;
    bit          restart;
    bit          lit;
    bit          lit_out;
    mesh_elem_t  elem;
  } plan_row_t;

  typedef enum logic [1:0] {
    GEN_VERTICES  = 2'd0,
    GEN_TRIANGLES = 2'd1,
    GEN_DONE      = 2'd2
  } gen_phase_t;

  typedef enum int {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_PRESSURE
  } idle_mode_t;

  localparam mesh_elem_t TOP_VERTEX = '{kind: KIND_VERTEX, x: 16'sd0, y: 16'sd0,
                                        z: 16'sd32767, i1: '0, i2: '0, i3: '0,
                                        last: 1'b0};
  localparam mesh_elem_t NO_ELEM = '0;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [7:0]    s_tdata = '0;     // [0] restart
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [103:0]  m_tdata;          // coord_x, coord_y, coord_z, index_first,
                                   // index_second, index_third
  logic          m_tuser;          // elem_kind
  logic          m_tlast;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = '0;
  logic [15:0]   cfg_data = '0;

  uv_sphere_mesh_generator #(
    .MAX_SECTORS(MAX_S),
    .MAX_STACKS (MAX_T)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // model copy of registers and generator state
  logic [8:0]  sect_cnt   = RST_SECTOR_COUNT;
  logic [8:0]  stack_cnt  = RST_STACK_COUNT;
  logic [15:0] sect_inc   = RST_SECTOR_STEP;
  logic [15:0] stk_inc    = RST_STACK_STEP;
  gen_phase_t  gen_ph     = GEN_VERTICES;
  logic [8:0]  row_q      = '0;
  logic [8:0]  col_q      = '0;
  logic        half_q     = 1'b0;
  logic [16:0] base_q     = '0;

  mesh_elem_t  elems_due[$];
  item_note_t  item_notes[$];
  plan_row_t   plan[$];
  int          err_cnt = 0;
  int          quiet_cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;

  function automatic int unsigned eff_cnt(input logic [8:0] v, input int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  // odd polynomial over the first quadrant, x in 0..quarter turn
  function automatic logic [15:0] sin_quad(input logic [14:0] x);
    logic [63:0] t, t2, p, s;
    t  = 64'(x) << 16;
    t2 = (t * t) >> 30;
    p  = 64'(SIN_C9);
    p  = 64'(SIN_C7) - ((t2 * p) >> 30);
    p  = 64'(SIN_C5) - ((t2 * p) >> 30);
    p  = 64'(SIN_C3) - ((t2 * p) >> 30);
    p  = 64'(SIN_C1) - ((t2 * p) >> 30);
    s  = (((t * p) >> 30) + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[15:0];
  endfunction

  function automatic logic signed [15:0] sin_of(input logic [15:0] a);
    logic [15:0] m;
    if (a[14]) m = sin_quad(15'(QUARTER_TURN - {2'b00, a[13:0]}));
    else m = sin_quad({1'b0, a[13:0]});
    return a[15] ? -m : m;
  endfunction

  function automatic logic signed [15:0] cos_of(input logic [15:0] a);
    return sin_of(a + QUARTER_TURN);
  endfunction

  // sign-magnitude q15 product, magnitude rounded half up
  function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    int ia, ib, prod;
    bit neg;
    ia   = a;
    ib   = b;
    neg  = (ia < 0) != (ib < 0);
    ia   = (ia < 0) ? -ia : ia;
    ib   = (ib < 0) ? -ib : ib;
    prod = (ia * ib + 16384) >>> 15;
    return neg ? -16'(prod) : 16'(prod);
  endfunction

  // move to the next triangle slot of the grid
  function automatic void tri_step(input int unsigned s, input int unsigned t);
    if (!half_q) begin
      half_q = 1'b1;
      return;
    end
    half_q = 1'b0;
    col_q  = col_q + 1'b1;
    if (32'(col_q) >= s) begin
      col_q = '0;
      row_q = row_q + 1'b1;
      if (32'(row_q) >= t) gen_ph = GEN_DONE;
    end
  endfunction

  // skip the upper triangles of the top row and the lower ones of the bottom row
  function automatic void tri_settle(input int unsigned s, input int unsigned t);
    bit skip;
    while (gen_ph == GEN_TRIANGLES) begin
      if (32'(row_q) >= t) begin
        gen_ph = GEN_DONE;
        break;
      end
      skip = (!half_q && row_q == 0) || (half_q && 32'(row_q) + 1 >= t);
      if (!skip) break;
      tri_step(s, t);
    end
    base_q = 17'(32'(row_q) * (s + 1) + 32'(col_q));
  endfunction

  // element caused by one advance item, 0 when the mesh is complete
  function automatic bit next_element(input bit restart, output mesh_elem_t e);
    int unsigned s, t;
    logic [15:0] v, u;
    logic signed [15:0] cv;
    logic [16:0] a, b;
    s = eff_cnt(sect_cnt, MAX_S);
    t = eff_cnt(stack_cnt, MAX_T);
    e = '0;
    if (restart) begin
      gen_ph = GEN_VERTICES;
      row_q  = '0;
      col_q  = '0;
      half_q = 1'b0;
      base_q = '0;
    end
    if (gen_ph != GEN_VERTICES && gen_ph != GEN_TRIANGLES) return 1'b0;
    if (gen_ph == GEN_VERTICES) begin
      v  = 16'(32'(QUARTER_TURN) - 32'(row_q) * 32'(stk_inc));
      u  = 16'(32'(col_q) * 32'(sect_inc));
      cv = cos_of(v);
      e.kind = KIND_VERTEX;
      e.x = mul_q15(cv, cos_of(u));
      e.y = mul_q15(cv, sin_of(u));
      e.z = sin_of(v);
      col_q = col_q + 1'b1;
      if (32'(col_q) >= s + 1) begin
        col_q = '0;
        row_q = row_q + 1'b1;
        if (32'(row_q) >= t + 1) begin
          row_q  = '0;
          half_q = 1'b0;
          gen_ph = GEN_TRIANGLES;
          tri_settle(s, t);
        end
      end
    end else begin
      a = 17'(32'(row_q) * (s + 1) + 32'(col_q));
      b = 17'(32'(a) + s + 1);
      e.kind = KIND_TRIANGLE;
      if (!half_q) begin
        e.i1 = a;
        e.i2 = b;
        e.i3 = a + 1'b1;
      end else begin
        e.i1 = a + 1'b1;
        e.i2 = b;
        e.i3 = b + 1'b1;
      end
      tri_step(s, t);
      tri_settle(s, t);
    end
    e.last = (gen_ph == GEN_DONE);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      err_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      m_tready   <= 1'b0;
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // track config and items, predict, compare elements, watchdog
  always @(posedge clk) begin
    mesh_elem_t want, got;
    item_note_t note;
    bit has;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SECTOR_COUNT: sect_cnt  = cfg_data[8:0];
          CFG_STACK_COUNT:  stack_cnt = cfg_data[8:0];
          CFG_SECTOR_STEP:  sect_inc  = cfg_data;
          CFG_STACK_STEP:   stk_inc   = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        note = item_notes.pop_front();
        has  = next_element(s_tdata[0], want);
        if (note.lit) begin
          if (note.lit_out) elems_due.push_back(note.elem);
        end else if (has) begin
          elems_due.push_back(want);
        end
      end
      if (m_tvalid && m_tready) begin
        got.kind = elem_kind_t'(m_tuser);
        got.x    = m_tdata[15:0];
        got.y    = m_tdata[31:16];
        got.z    = m_tdata[47:32];
        got.i1   = m_tdata[64:48];
        got.i2   = m_tdata[81:65];
        got.i3   = m_tdata[98:82];
        got.last = m_tlast;
        if (elems_due.size() == 0) begin
          err_cnt++;
          $display("%0t: element expected none, got kind %0d", $time, got.kind);
        end else begin
          want = elems_due.pop_front();
          check_field("elem_kind", want.kind, got.kind);
          check_field("coord_x", want.x, got.x);
          check_field("coord_y", want.y, got.y);
          check_field("coord_z", want.z, got.z);
          check_field("index_first", want.i1, got.i1);
          check_field("index_second", want.i2, got.i2);
          check_field("index_third", want.i3, got.i3);
          check_field("last", want.last, got.last);
        end
      end
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // offer one advance item, with random gaps before it
  task automatic send_item(input bit restart, input bit lit, input bit lit_out,
                           input mesh_elem_t elem);
    item_notes.push_back('{lit, lit_out, elem});
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!s_tready);
  endtask

  // wait until every element is back and the pipeline has drained
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (elems_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // caller lowers cfg_valid after the last write of a group
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic plan_cfg(input logic [1:0] idx, input logic [15:0] data);
    plan.push_back('{1'b1, idx, data, 1'b0, 1'b0, 1'b0, NO_ELEM});
  endtask

  task automatic plan_item(input bit restart, input bit lit, input bit lit_out,
                           input mesh_elem_t elem);
    plan.push_back('{1'b0, 2'd0, 16'd0, restart, lit, lit_out, elem});
  endtask

  // count register value: mostly small, sometimes zero, at the bound or above it
  function automatic logic [15:0] pick_count();
    int r;
    logic [8:0] v;
    r = $urandom_range(0, 19);
    if (r == 0) v = 9'd0;
    else if (r == 1) v = 9'($urandom_range(257, 511));
    else if (r == 2) v = 9'd256;
    else v = 9'($urandom_range(1, 5));
    return {7'($urandom_range(0, 127)), v};
  endfunction

  // angle step: extremes, an even split, or anything
  function automatic logic [15:0] pick_step(input logic [15:0] count, input int unsigned full);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'(full / eff_cnt(count[8:0], MAX_S));
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    idle_mode_t  mode;
    int          sent, n, len;
    int unsigned se, te;
    bit          first, forced;
    logic [15:0] sc, tc, ss, ts;
    logic [1:0]  idx;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // out of reset: default 16 by 16 sphere
    plan_item(1'b1, 1'b1, 1'b1, TOP_VERTEX);
    plan_item(1'b0, 1'b0, 1'b0, NO_ELEM);
    // single stack with a zero sector count, steps at their maximum
    plan_cfg(CFG_SECTOR_COUNT, 16'h0000);
    plan_cfg(CFG_STACK_COUNT, 16'h0001);
    plan_cfg(CFG_SECTOR_STEP, 16'hFFFF);
    plan_cfg(CFG_STACK_STEP, 16'hFFFF);
    plan_item(1'b1, 1'b1, 1'b1, TOP_VERTEX);
    for (int k = 0; k < 3; k++) plan_item(1'b0, 1'b0, 1'b0, NO_ELEM);
    // advance after completion gives nothing
    for (int k = 0; k < 2; k++) plan_item(1'b0, 1'b1, 1'b0, NO_ELEM);
    // one sector, two stacks: six vertices, then two triangles
    plan_cfg(CFG_STACK_COUNT, 16'h0002);
    plan_cfg(CFG_SECTOR_STEP, 16'h0000);
    plan_cfg(CFG_STACK_STEP, 16'h8000);
    plan_item(1'b1, 1'b1, 1'b1, TOP_VERTEX);
    for (int k = 0; k < 5; k++) plan_item(1'b0, 1'b0, 1'b0, NO_ELEM);
    plan_item(1'b0, 1'b1, 1'b1, '{kind: KIND_TRIANGLE, x: 16'sd0, y: 16'sd0, z: 16'sd0,
                                  i1: 17'd1, i2: 17'd2, i3: 17'd3, last: 1'b0});
    plan_item(1'b0, 1'b1, 1'b1, '{kind: KIND_TRIANGLE, x: 16'sd0, y: 16'sd0, z: 16'sd0,
                                  i1: 17'd2, i2: 17'd4, i3: 17'd3, last: 1'b1});
    plan_item(1'b0, 1'b1, 1'b0, NO_ELEM);
    // counts at and above the bound, restart in the middle of a mesh
    plan_cfg(CFG_SECTOR_COUNT, 16'hFFFF);
    plan_cfg(CFG_STACK_COUNT, 16'h0100);
    plan_cfg(CFG_SECTOR_STEP, 16'd256);
    plan_cfg(CFG_STACK_STEP, 16'd128);
    plan_item(1'b1, 1'b1, 1'b1, TOP_VERTEX);
    for (int k = 0; k < 2; k++) plan_item(1'b0, 1'b0, 1'b0, NO_ELEM);
    plan_item(1'b1, 1'b1, 1'b1, TOP_VERTEX);
    plan_item(1'b0, 1'b0, 1'b0, NO_ELEM);

    // walk the directed table
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_idle();
        write_reg(plan[i].idx, plan[i].data);
        if (i + 1 == plan.size() || !plan[i+1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_item(plan[i].restart, plan[i].lit, plan[i].lit_out, plan[i].elem);
      end
    end

    // random meshes under each idling pattern
    for (int p = IDLE_NONE; p <= IDLE_PRESSURE; p++) begin
      mode = idle_mode_t'(p);
      case (mode)
        IDLE_SENDER: begin
          gap_pct = 80;
          stall_pct <= 0;
        end
        IDLE_RECEIVER: begin
          gap_pct = 0;
          stall_pct <= 80;
        end
        IDLE_BOTH: begin
          gap_pct = 19;
          stall_pct <= 19;
        end
        default: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
      endcase
      sent  = 0;
      first = 1'b1;
      while (sent < ITEMS_PER_PHASE) begin
        wait_idle();
        // the held-off mesh is long enough to fill the block
        forced = (mode == IDLE_PRESSURE) && first;
        sc = forced ? 16'd4 : pick_count();
        tc = forced ? 16'd4 : pick_count();
        ss = pick_step(sc, 65536);
        ts = pick_step(tc, 32768);
        write_reg(CFG_SECTOR_COUNT, sc);
        write_reg(CFG_STACK_COUNT, tc);
        write_reg(CFG_SECTOR_STEP, ss);
        write_reg(CFG_STACK_STEP, ts);
        cfg_valid <= 1'b0;
        se  = eff_cnt(sc[8:0], MAX_S);
        te  = eff_cnt(tc[8:0], MAX_T);
        len = (se + 1) * (te + 1) + 2 * se * te - 2 * se;
        n   = (len > 80) ? $urandom_range(10, 40) : len - 1 + $urandom_range(0, 2);
        send_item(1'b1, 1'b0, 1'b0, NO_ELEM);
        sent++;
        if (forced) hold_req <= 1'b1;
        first = 1'b0;
        for (int k = 1; k <= n; k++) begin
          // occasional register change in the middle of a mesh
          if (k == n / 2 && $urandom_range(0, 3) == 0) begin
            idx = 2'($urandom_range(0, 3));
            wait_idle();
            if (idx == CFG_SECTOR_COUNT || idx == CFG_STACK_COUNT)
              write_reg(idx, pick_count());
            else
              write_reg(idx, pick_step(sc, 65536));
            cfg_valid <= 1'b0;
          end
          send_item($urandom_range(0, 39) == 0, 1'b0, 1'b0, NO_ELEM);
          sent++;
        end
      end
    end

    wait_idle();
    if (err_cnt == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
